FILE: hw/rtl/ghacc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ghacc_pkg
// Shared codes, configuration and operation types of the histogram builder.
// ---------------------------------------------------------------------------
package ghacc_pkg;

  localparam logic [1:0] CMD_ACC   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] CFG_VLEN = 3'd0;
  localparam logic [2:0] CFG_CLS  = 3'd1;
  localparam logic [2:0] CFG_BPI  = 3'd2;
  localparam logic [2:0] CFG_IPP  = 3'd3;
  localparam logic [2:0] CFG_ZDIM = 3'd4;

  localparam logic [1:0] OP_ACC   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // widest bin index and class index the parameters allow
  localparam int BIN_MAX_W = 16;
  localparam int CLS_MAX_W = 6;

  typedef struct packed {
    logic [3:0] vector_length;
    logic       is_classification;
    logic [6:0] bits_per_item;
    logic [6:0] items_per_pack;
    logic       zero_dims;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic                 bin_ok;
    logic                 start;
    logic                 hess_en;
    logic [BIN_MAX_W-1:0] bin;
    logic [CLS_MAX_W-1:0] elem;
    logic [15:0]          occ;
    logic [31:0]          weight;
    logic signed [31:0]   grad;
    logic signed [31:0]   hess;
  } op_t;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  // unsigned Q16.16 times signed Q8.24, floored to Q32.32
  function automatic logic signed [63:0] scale(input logic [31:0] w,
                                               input logic signed [31:0] v);
    logic signed [64:0] p;
    p = $signed({1'b0, w}) * $signed({v[31], v});
    return {{8{p[63]}}, p[63:8]};
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ghacc_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ghacc_if
// Valid/ready channels for command items and read results.
// ---------------------------------------------------------------------------
interface ghacc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [63:0]        packed_word;
  logic [15:0]        occurrence_count;
  logic [31:0]        sample_weight;
  logic signed [31:0] gradient;
  logic signed [31:0] hessian;
  logic [7:0]         read_bin;
  logic [2:0]         read_class;
  modport source (output valid, command, packed_word, occurrence_count, sample_weight,
                  gradient, hessian, read_bin, read_class, input ready);
  modport sink (input valid, command, packed_word, occurrence_count, sample_weight,
                gradient, hessian, read_bin, read_class, output ready);
endinterface

interface ghacc_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        bin_count;
  logic [63:0]        weight_sum;
  logic signed [63:0] gradient_sum;
  logic signed [63:0] hessian_sum;
  modport source (output valid, bin_count, weight_sum, gradient_sum, hessian_sum,
                  input ready);
  modport sink (input valid, bin_count, weight_sum, gradient_sum, hessian_sum,
                output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ghacc_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ghacc_ram
// Generic one-write, one-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ghacc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/ghacc_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ghacc_front
// Accepts command items, extracts bin indexes and tracks sample elements.
// ---------------------------------------------------------------------------
module ghacc_front #(
  parameter int BINS    = 256,
  parameter int CLASSES = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ghacc_pkg::cfg_t cfg,
  ghacc_in_if.sink             in_ch,
  output logic                 push,
  output ghacc_pkg::op_t       push_op,
  input  wire logic            q_ready
);
  import ghacc_pkg::*;

  logic [63:0] held_word, held_word_next;
  logic [6:0]  slot, slot_next;
  logic [3:0]  elem, elem_next;
  logic [BIN_MAX_W-1:0] cur_bin, cur_bin_next;
  logic        cur_ok, cur_ok_next;

  logic [3:0]  vl_raw, vl, ec;
  logic [6:0]  ipp, bpi, s;
  logic [63:0] w, mask, idx;
  logic        accept, reload, start;

  assign in_ch.ready = q_ready;
  assign accept = in_ch.valid & q_ready;

  always_comb begin
    vl_raw = (cfg.vector_length == 4'd0) ? 4'd1 : cfg.vector_length;
    vl = (32'(vl_raw) > CLASSES) ? 4'(CLASSES) : vl_raw;
    ec = (elem >= vl) ? vl - 4'd1 : elem;
    start = (ec == 4'd0);
    ipp = (cfg.items_per_pack == 7'd0) ? 7'd1 : cfg.items_per_pack;
    bpi = (cfg.bits_per_item > 7'd64) ? 7'd64 : cfg.bits_per_item;
    reload = (slot == 7'd0) || (slot >= ipp);
    w = reload ? in_ch.packed_word : held_word;
    s = reload ? 7'd0 : slot;
    mask = (bpi >= 7'd64) ? {64{1'b1}} : ~({64{1'b1}} << bpi);
    idx = cfg.zero_dims ? 64'd0 : (w & mask);

    held_word_next = held_word;
    slot_next = slot;
    cur_bin_next = cur_bin;
    cur_ok_next = cur_ok;
    elem_next = elem;
    push = 1'b0;
    push_op = '0;
    if (accept) begin
      unique case (in_ch.command)
        CMD_ACC: begin
          if (start) begin
            if (!cfg.zero_dims) begin
              held_word_next = (bpi >= 7'd64) ? 64'd0 : (w >> bpi);
              slot_next = (s + 7'd1 >= ipp) ? 7'd0 : s + 7'd1;
            end
            cur_ok_next = idx < 64'(BINS);
            cur_bin_next = BIN_MAX_W'(idx);
          end
          elem_next = (ec + 4'd1 >= vl) ? 4'd0 : ec + 4'd1;
          push = 1'b1;
          push_op.kind = OP_ACC;
          push_op.bin_ok = cur_ok_next;
          push_op.bin = cur_bin_next;
          push_op.start = start;
          push_op.elem = CLS_MAX_W'(ec);
        end
        CMD_READ: begin
          push = 1'b1;
          push_op.kind = OP_READ;
          push_op.bin_ok = (32'(in_ch.read_bin) < BINS) && (32'(in_ch.read_class) < CLASSES);
          push_op.bin = BIN_MAX_W'(in_ch.read_bin);
          push_op.elem = CLS_MAX_W'(in_ch.read_class);
        end
        CMD_CLEAR: begin
          held_word_next = 64'd0;
          slot_next = 7'd0;
          elem_next = 4'd0;
          cur_bin_next = '0;
          cur_ok_next = 1'b1;
          push = 1'b1;
          push_op.kind = OP_CLEAR;
        end
        default: begin
          // unused command: drop
        end
      endcase
      push_op.hess_en = cfg.is_classification;
      push_op.occ = in_ch.occurrence_count;
      push_op.weight = in_ch.sample_weight;
      push_op.grad = in_ch.gradient;
      push_op.hess = in_ch.hessian;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_word <= 64'd0;
      slot <= 7'd0;
      elem <= 4'd0;
      cur_bin <= '0;
      cur_ok <= 1'b1;
    end else begin
      held_word <= held_word_next;
      slot <= slot_next;
      elem <= elem_next;
      cur_bin <= cur_bin_next;
      cur_ok <= cur_ok_next;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/ghacc_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ghacc_queue
// Two-entry queue of classified operations between front and back.
// ---------------------------------------------------------------------------
module ghacc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire ghacc_pkg::op_t push_op,
  output logic                ready,
  input  wire logic           pop,
  output logic                valid,
  output ghacc_pkg::op_t      op
);
  import ghacc_pkg::*;

  op_t        slots [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign op = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/ghacc_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ghacc_back
// Executes operations on the bin stores: accumulate, read and clear sweep.
// ---------------------------------------------------------------------------
module ghacc_back #(
  parameter int BINS    = 256,
  parameter int CLASSES = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire ghacc_pkg::op_t q_op,
  output logic                q_pop,
  ghacc_out_if.source         out_ch
);
  import ghacc_pkg::*;

  localparam int BIN_W = $clog2(BINS);
  localparam int KDEPTH = BINS * CLASSES;
  localparam int K_W = $clog2(KDEPTH);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_RDW  = 3'd3;

  logic [2:0]  state, state_next;
  logic [K_W-1:0] clr_addr;
  op_t         cur;
  logic signed [63:0] prod_g, prod_h;

  logic [BIN_W-1:0] b_raddr, b_waddr;
  logic [K_W-1:0]   k_raddr, k_waddr;
  logic             re, b_we, g_we, h_we;
  logic [31:0]      cnt_rd, cnt_wd;
  logic [63:0]      wt_rd, wt_wd;
  logic signed [63:0] g_rd, g_wd, h_rd, h_wd;
  logic [32:0]      cnt_sum;
  logic [64:0]      wt_sum;
  logic             load_out;

  logic               out_valid;
  logic [31:0]        out_bc;
  logic [63:0]        out_ws;
  logic signed [63:0] out_gs, out_hs;

  assign out_ch.valid = out_valid;
  assign out_ch.bin_count = out_bc;
  assign out_ch.weight_sum = out_ws;
  assign out_ch.gradient_sum = out_gs;
  assign out_ch.hessian_sum = out_hs;

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    re = 1'b0;
    load_out = 1'b0;
    b_raddr = BIN_W'(q_op.bin);
    k_raddr = K_W'(32'(q_op.bin) * CLASSES + 32'(q_op.elem));
    cnt_sum = 33'(cnt_rd) + 33'(cur.occ);
    wt_sum = 65'(wt_rd) + 65'(cur.weight);
    cnt_wd = cnt_sum[32] ? {32{1'b1}} : cnt_sum[31:0];
    wt_wd = wt_sum[64] ? {64{1'b1}} : wt_sum[63:0];
    g_wd = sat_add64(g_rd, prod_g);
    h_wd = sat_add64(h_rd, prod_h);
    b_waddr = BIN_W'(cur.bin);
    k_waddr = K_W'(32'(cur.bin) * CLASSES + 32'(cur.elem));
    b_we = 1'b0;
    g_we = 1'b0;
    h_we = 1'b0;
    unique case (state)
      S_CLR: begin
        b_waddr = BIN_W'(clr_addr);
        k_waddr = clr_addr;
        cnt_wd = '0;
        wt_wd = '0;
        g_wd = '0;
        h_wd = '0;
        b_we = 32'(clr_addr) < BINS;
        g_we = 1'b1;
        h_we = 1'b1;
        if (32'(clr_addr) == KDEPTH - 1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_op.kind)
            OP_ACC: begin
              re = 1'b1;
              state_next = S_ACC;
            end
            OP_READ: begin
              re = 1'b1;
              state_next = S_RDW;
            end
            OP_CLEAR: state_next = S_CLR;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ACC: begin
        b_we = cur.start & cur.bin_ok;
        g_we = cur.bin_ok;
        h_we = cur.bin_ok & cur.hess_en;
        state_next = S_IDLE;
      end
      S_RDW: begin
        if (!out_valid || out_ch.ready) begin
          load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLR) begin
        clr_addr <= clr_addr + K_W'(1);
      end else begin
        clr_addr <= '0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_op;
      prod_g <= scale(q_op.weight, q_op.grad);
      prod_h <= scale(q_op.weight, q_op.hess);
    end
    if (load_out) begin
      out_bc <= cur.bin_ok ? cnt_rd : '0;
      out_ws <= cur.bin_ok ? wt_rd : '0;
      out_gs <= cur.bin_ok ? g_rd : '0;
      out_hs <= cur.bin_ok ? h_rd : '0;
    end
  end

  ghacc_ram #(.WIDTH(32), .DEPTH(BINS)) u_cnt (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(cnt_wd),
    .re(re), .raddr(b_raddr), .rdata(cnt_rd));
  ghacc_ram #(.WIDTH(64), .DEPTH(BINS)) u_wt (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(wt_wd),
    .re(re), .raddr(b_raddr), .rdata(wt_rd));
  ghacc_ram #(.WIDTH(64), .DEPTH(KDEPTH)) u_grad (
    .clk(clk), .we(g_we), .waddr(k_waddr), .wdata(g_wd),
    .re(re), .raddr(k_raddr), .rdata(g_rd));
  ghacc_ram #(.WIDTH(64), .DEPTH(KDEPTH)) u_hess (
    .clk(clk), .we(h_we), .waddr(k_waddr), .wdata(h_wd),
    .re(re), .raddr(k_raddr), .rdata(h_rd));

`ifndef SYNTH
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !q_pop) else $error("queue popped during clear sweep");
  a_pop_idle_only: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE)) else $error("queue popped outside idle");
  a_acc_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |=> (state == S_IDLE)) else $error("accumulate write stuck");
`endif
endmodule
`default_nettype wire

FILE: hw/rtl/gradient_histogram_accumulator_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gradient_histogram_accumulator_top
// Gradient-boosting histogram builder: bin extraction front, store back end.
// ---------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  in_ch    in   valid/ready      command, packed word, weights, gradients
//  out_ch   out  valid/ready      bin count, weight, gradient, hessian sums
//  cfg      in   cfg_we only      cfg_index, cfg_data
//
// In the back end an accumulate is a RAM read, then a saturating write; a
// read is a RAM read, then a wait for the output register to be free;
// command 3 is dropped in the front and never reaches the back end.
// After reset, and in the cycle after a clear leaves the queue, the back
// end sweeps every store address, zeroing the stores; the queue then fills
// and input stalls.
// A two-entry queue lets the front keep accepting while the back end works.
// ---------------------------------------------------------------------------
module gradient_histogram_accumulator_top #(
  parameter int BINS    = 256,
  parameter int CLASSES = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  ghacc_in_if.sink        in_ch,
  ghacc_out_if.source     out_ch,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [6:0] cfg_data
);
  import ghacc_pkg::*;

  cfg_t cfg;
  logic push, q_ready, q_valid, q_pop;
  op_t  push_op, q_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vector_length <= 4'd1;
      cfg.is_classification <= 1'b0;
      cfg.bits_per_item <= 7'd8;
      cfg.items_per_pack <= 7'd8;
      cfg.zero_dims <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VLEN: cfg.vector_length <= cfg_data[3:0];
        CFG_CLS:  cfg.is_classification <= cfg_data[0];
        CFG_BPI:  cfg.bits_per_item <= cfg_data;
        CFG_IPP:  cfg.items_per_pack <= cfg_data;
        CFG_ZDIM: cfg.zero_dims <= cfg_data[0];
        default: begin
          // no register here: drop
        end
      endcase
    end
  end

  ghacc_front #(.BINS(BINS), .CLASSES(CLASSES)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .in_ch(in_ch),
    .push(push), .push_op(push_op), .q_ready(q_ready));

  ghacc_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_op(push_op), .ready(q_ready),
    .pop(q_pop), .valid(q_valid), .op(q_op));

  ghacc_back #(.BINS(BINS), .CLASSES(CLASSES)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_op(q_op), .q_pop(q_pop),
    .out_ch(out_ch));
endmodule
`default_nettype wire
